@@ rtl/adjacency_to_grid_edges_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency-to-grid-edges core
// Shared helpers for concurrent checks on aclk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_TO_GRID_EDGES_CORE_MACROS_SVH
`define ADJACENCY_TO_GRID_EDGES_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AGEC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define AGEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/agec_pkg.sv @@
// ----------------------------------------------------------------------------
// agec_pkg
// Types and constants shared by the adjacency-to-grid-edges core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package agec_pkg;

    localparam int ID_W       = 48;           // vertex id width
    localparam int ACC_W      = 40;           // bytes held before the last one
    localparam int POS_W      = 3;            // byte position within a word
    localparam int WORD_BYTES = 6;
    localparam int CELL_W     = 32;
    localparam int LOCAL_W    = 24;
    localparam int DATA_W     = 8;
    localparam int OUT_W      = 2 * CELL_W + 2 * LOCAL_W;

    // Grid width is a power of two: divide is a shift, modulo is a mask.
    localparam int GRID_SHIFT = 24;           // 16 .. 24 so ids fit the cell and local fields
    localparam logic [ID_W-1:0] GRID_MASK = (ID_W'(1) << GRID_SHIFT) - ID_W'(1);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORD_BYTES - 1);

    typedef enum logic [1:0] {
        PH_SOURCE = 2'd0,
        PH_COUNT  = 2'd1,
        PH_NEIGH  = 2'd2
    } phase_t;

    // One ordered edge from the parser to the output stage.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] big;
        logic [ID_W-1:0] small_id;
    } edge_t;

endpackage

`default_nettype wire

@@ rtl/agec_parser.sv @@
// ----------------------------------------------------------------------------
// agec_parser
// Byte-level parser of adjacency lists; emits ordered, non-self-loop edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agec_parser
    import agec_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [DATA_W-1:0] data_byte,
    input  wire logic              stream_start,
    output edge_t                  edge_out
);

    logic [ACC_W-1:0] acc_reg, acc_next, acc_eff;
    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    phase_t           phase_reg, phase_next, phase_eff;
    logic [ID_W-1:0]  src_reg, src_next, src_eff;
    logic [ID_W-1:0]  left_reg, left_next, left_eff;
    logic [ID_W-1:0]  word;
    logic [ID_W-1:0]  left_dec;
    logic             src_gt;

    always_comb begin
        // A start flag restarts the parse before this byte is used.
        acc_eff   = stream_start ? '0 : acc_reg;
        pos_eff   = stream_start ? '0 : pos_reg;
        phase_eff = stream_start ? PH_SOURCE : phase_reg;
        src_eff   = stream_start ? '0 : src_reg;
        left_eff  = stream_start ? '0 : left_reg;

        word     = {acc_eff, data_byte};
        left_dec = left_eff - ID_W'(1);
        src_gt   = src_eff > word;

        acc_next   = acc_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        src_next   = src_reg;
        left_next  = left_reg;

        edge_out.valid    = 1'b0;
        edge_out.big      = src_gt ? src_eff : word;
        edge_out.small_id = src_gt ? word : src_eff;

        if (accept) begin
            acc_next   = acc_eff;
            pos_next   = pos_eff;
            phase_next = phase_eff;
            src_next   = src_eff;
            left_next  = left_eff;
            if (pos_eff < LAST_POS) begin
                acc_next = {acc_eff[ACC_W-DATA_W-1:0], data_byte};
                pos_next = pos_eff + POS_W'(1);
            end else begin
                acc_next = '0;
                pos_next = '0;
                case (phase_eff)
                    PH_COUNT: begin
                        if (word == '0) begin
                            phase_next = PH_SOURCE;
                        end else begin
                            left_next  = word;
                            phase_next = PH_NEIGH;
                        end
                    end
                    PH_NEIGH: begin
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            phase_next = PH_SOURCE;
                        end
                        // drop self-loops
                        edge_out.valid = (word != src_eff);
                    end
                    default: begin
                        src_next   = word;
                        phase_next = PH_COUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            pos_reg   <= '0;
            phase_reg <= PH_SOURCE;
            src_reg   <= '0;
            left_reg  <= '0;
        end else begin
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            src_reg   <= src_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/agec_out.sv @@
// ----------------------------------------------------------------------------
// agec_out
// Output register with a skid stage; splits each id into cell and offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module agec_out
    import agec_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire edge_t            edge_in,
    output logic                  in_ready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;
    logic [OUT_W-1:0] packed_edge;
    logic [ID_W-1:0]  big_low, small_low;

    always_comb begin
        big_low     = edge_in.big & GRID_MASK;
        small_low   = edge_in.small_id & GRID_MASK;
        packed_edge = {LOCAL_W'(small_low),
                       LOCAL_W'(big_low),
                       CELL_W'(edge_in.small_id >> GRID_SHIFT),
                       CELL_W'(edge_in.big >> GRID_SHIFT)};

        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || m_tready) begin
            // output slot frees up: drain the skid stage first
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = edge_in.valid;
                out_data_next  = packed_edge;
            end
        end else if (edge_in.valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = packed_edge;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/adjacency_to_grid_edges_core.sv @@
// ----------------------------------------------------------------------------
// adjacency_to_grid_edges_core
// Parses an adjacency-list byte stream into grid-partitioned edges.
// ----------------------------------------------------------------------------
// The core takes one byte per item and accepts an item in every cycle while
// its skid stage is empty, so the sustained rate is one byte per clock; a
// result is held in the output register, or in the skid stage on a stall,
// from the byte that completes its neighbour word. Ids are 48-bit words sent
// most significant byte first; each list is a source id, a neighbour count,
// then that many neighbours. An edge is emitted per neighbour with the
// larger id as the row: cell fields are the ids divided by the grid width
// (2^GRID_SHIFT), local fields the ids masked by it. Self-loops give no
// result, a zero count moves straight to the next source, and tuser set on
// a byte restarts the parse with that byte as the first of a source id.
// Only the skid stage filling while the output is stalled holds s_tready low.
`timescale 1ns / 1ps
`default_nettype none

`include "adjacency_to_grid_edges_core_macros.svh"

module adjacency_to_grid_edges_core
    import agec_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  wire logic              s_tuser,   // [0] stream_start
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata    // [31:0] cell_row, [63:32] cell_col,
                                              // [87:64] local_row, [111:88] local_col
);

    logic  accept;
    edge_t parsed_edge;

    // advance the parser on every accepted item
    assign accept = s_tvalid && s_tready;

    agec_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .data_byte    (s_tdata),
        .stream_start (s_tuser),
        .edge_out     (parsed_edge)
    );

    // hold results in the output register, spill into the skid stage on stall
    agec_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .edge_in  (parsed_edge),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // An edge only arises from an accepted item.
    `AGEC_ASSERT_SAME(a_edge_needs_accept, aclk, aresetn, parsed_edge.valid, accept, "stray edge")
    // After every edge, m_tvalid is high in the next cycle.
    `AGEC_ASSERT_NEXT(a_edge_reaches_out, aclk, aresetn, parsed_edge.valid, m_tvalid, "edge lost")
    // A full skid stage implies a waiting result.
    `AGEC_ASSERT_SAME(a_stall_has_result, aclk, aresetn, !s_tready, m_tvalid, "empty stall")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adjacency-to-grid-edges core: a byte driver
// fed from a queue of pending stream bytes, a result monitor, and an
// in-bench parser that predicts every grid edge from the accepted bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import agec_pkg::*;

    localparam int HOLD_AT     = 850;     // bytes sent before the long receiver hold-off
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 300000;

    // m_tdata layout, lowest field last in the packed order
    typedef struct packed {
        logic [LOCAL_W-1:0] local_col;
        logic [LOCAL_W-1:0] local_row;
        logic [CELL_W-1:0]  cell_col;
        logic [CELL_W-1:0]  cell_row;
    } grid_edge_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] data;
    } stream_byte_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    adjacency_to_grid_edges_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    stream_byte_t stream_q[$];
    grid_edge_t   edges_due[$];
    int           bytes_queued   = 0;
    int           bytes_sent     = 0;
    int           errors         = 0;
    int           cycles         = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           hold_left      = 0;
    bit           hold_armed     = 1'b1;
    bit           need_restart   = 1'b0;

    // Parser state as the block should hold it
    logic [ACC_W-1:0] acc_bytes;
    logic [POS_W-1:0] held_count;
    phase_t           phase;
    logic [ID_W-1:0]  list_source;
    logic [ID_W-1:0]  neigh_due;

    function automatic void clear_parser();
        acc_bytes   = '0;
        held_count  = '0;
        phase       = PH_SOURCE;
        list_source = '0;
        neigh_due   = '0;
    endfunction

    // Advance the parser by one byte; return 1 and the edge when a result is due.
    function automatic bit parse_adjacency_byte(input logic [DATA_W-1:0] b, input logic start,
                                                output grid_edge_t res);
        logic [ID_W-1:0] word;
        logic [ID_W-1:0] hi_id;
        logic [ID_W-1:0] lo_id;
        res = '0;
        if (start)
            clear_parser();
        if (held_count < LAST_POS) begin
            acc_bytes  = {acc_bytes[ACC_W-DATA_W-1:0], b};
            held_count = held_count + POS_W'(1);
            return 1'b0;
        end
        word       = {acc_bytes, b};
        acc_bytes  = '0;
        held_count = '0;
        if (phase == PH_COUNT) begin
            // a zero count skips straight to the next source
            if (word == '0) begin
                phase = PH_SOURCE;
            end else begin
                neigh_due = word;
                phase     = PH_NEIGH;
            end
            return 1'b0;
        end
        if (phase != PH_NEIGH) begin
            list_source = word;
            phase       = PH_COUNT;
            return 1'b0;
        end
        neigh_due = neigh_due - ID_W'(1);
        if (neigh_due == '0)
            phase = PH_SOURCE;
        // self-loop: neighbour consumed, nothing emitted
        if (word == list_source)
            return 1'b0;
        hi_id = (list_source > word) ? list_source : word;
        lo_id = (list_source > word) ? word : list_source;
        res.cell_row  = CELL_W'(hi_id >> GRID_SHIFT);
        res.cell_col  = CELL_W'(lo_id >> GRID_SHIFT);
        res.local_row = LOCAL_W'(hi_id & GRID_MASK);
        res.local_col = LOCAL_W'(lo_id & GRID_MASK);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [DATA_W-1:0] b, input logic start);
        stream_byte_t item;
        item.data  = b;
        item.start = start;
        stream_q = {stream_q, item};
        bytes_queued++;
    endtask

    // Ids go out most significant byte first; start marks only the first byte.
    task automatic queue_word(input logic [ID_W-1:0] id, input logic start);
        for (int i = WORD_BYTES - 1; i >= 0; i--)
            queue_byte(id[i*DATA_W +: DATA_W], (i == WORD_BYTES - 1) ? start : 1'b0);
    endtask

    function automatic logic [ID_W-1:0] pick_vertex(input logic [ID_W-1:0] src);
        int k;
        k = $urandom_range(99);
        if (k < 15)
            return src;
        if (k < 30)
            return ID_W'($urandom_range(0, 255));
        if (k < 45)
            return {ID_W{1'b1}} - ID_W'($urandom_range(0, 255));
        if (k < 60)
            return (src & ~GRID_MASK) | (ID_W'($urandom) & GRID_MASK);
        return ID_W'({$urandom, $urandom});
    endfunction

    // One list, mostly well formed; some have a count longer than what follows,
    // some trail off into a partial word, both forcing a restart on the next list.
    task automatic queue_random_list();
        logic [ID_W-1:0] src;
        logic [ID_W-1:0] cnt;
        int              n;
        int              k;
        src = pick_vertex(ID_W'({$urandom, $urandom}));
        queue_word(src, need_restart || ($urandom_range(99) < 5));
        need_restart = 1'b0;
        k = $urandom_range(99);
        if (k < 15) begin
            cnt = '0;
            n   = 0;
        end else if (k < 23) begin
            cnt = ID_W'({$urandom, $urandom}) | ID_W'(8);
            n   = $urandom_range(1, 4);
            need_restart = 1'b1;
        end else begin
            n   = $urandom_range(1, 5);
            cnt = ID_W'(n);
        end
        queue_word(cnt, 1'b0);
        for (int i = 0; i < n; i++)
            queue_word(pick_vertex(src), 1'b0);
        if ($urandom_range(99) < 8) begin
            n = $urandom_range(1, WORD_BYTES - 1);
            for (int i = 0; i < n; i++)
                queue_byte(DATA_W'($urandom), 1'b0);
            need_restart = 1'b1;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (bytes_sent != bytes_queued || edges_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Byte driver: predict on acceptance, then offer the next byte
    // ------------------------------------------------------------------
    grid_edge_t predicted;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            clear_parser();
        end else begin
            if (s_tvalid && s_tready) begin
                if (parse_adjacency_byte(s_tdata, s_tuser, predicted))
                    edges_due = {edges_due, predicted};
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stream_q[0].data;
                    s_tuser  <= stream_q[0].start;
                    void'(stream_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, armed once the stream is well under way
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && bytes_sent >= HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [CELL_W-1:0] want,
                               input logic [CELL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    grid_edge_t seen;
    grid_edge_t wanted;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = grid_edge_t'(m_tdata);
                if (edges_due.size() == 0) begin
                    $display("%0t: expected no edge, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    wanted = edges_due.pop_front();
                    check_field("cell_row", wanted.cell_row, seen.cell_row);
                    check_field("cell_col", wanted.cell_col, seen.cell_col);
                    check_field("local_row", CELL_W'(wanted.local_row), CELL_W'(seen.local_row));
                    check_field("local_col", CELL_W'(wanted.local_col), CELL_W'(seen.local_col));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed lists, then three randomised phases
    // ------------------------------------------------------------------
    initial begin
        int phase_end;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes: a mid-range source against id zero (smaller), the all-ones
        // id (larger) and itself (self-loop); then a zero count, then a
        // trailing partial word dropped by the restart that follows.
        queue_word(ID_W'(48'h0000_0100_0000), 1'b1);
        queue_word(ID_W'(3), 1'b0);
        queue_word('0, 1'b0);
        queue_word({ID_W{1'b1}}, 1'b0);
        queue_word(ID_W'(48'h0000_0100_0000), 1'b0);
        queue_word(ID_W'(48'h1234_5678_9ABC), 1'b0);
        queue_word('0, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hA5, 1'b0);
        need_restart = 1'b1;
        // pause the sender until every directed edge is back
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 37 : (p == 1) ? 66 : 0;
            recv_idle_pct = (p == 0) ? 66 : (p == 1) ? 37 : 0;
            phase_end = bytes_queued + 350;
            while (bytes_queued < phase_end)
                queue_random_list();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && edges_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
